### rtl/core/bcd_decimal_arith_unit_assert.svh
// Assertion macros shared by the BCD arithmetic unit
`ifndef BCD_DECIMAL_ARITH_UNIT_ASSERT_SVH
`define BCD_DECIMAL_ARITH_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bda_pkg.sv
// Package with widths, opcodes and control types of the BCD arithmetic unit
package bda_pkg;

    localparam int NUM_DIGITS = 16;
    localparam int DIG_W      = 4;
    localparam int RES_W      = DIG_W * NUM_DIGITS;
    localparam int FIELD_W    = 64;
    localparam int INT_W      = 32;

    // largest digit product and column sum of the multiply window
    localparam int PROD_MAX  = 15 * 15;
    localparam int PROD_W    = 2 * DIG_W;
    localparam int COL_MAX   = NUM_DIGITS * PROD_MAX;
    localparam int COL_W     = $clog2(COL_MAX + 1);
    localparam int CARRY_MAX = COL_MAX / 9;
    localparam int CARRY_W   = $clog2(CARRY_MAX + 1);
    localparam int SUM_W     = $clog2(COL_MAX + CARRY_MAX + 1);

    // divide by ten: q = (t * RECIP) >> RECIP_SH, exact for t below 16384
    localparam int RECIP    = 3277;
    localparam int RECIP_W  = 12;
    localparam int RECIP_SH = 15;

    // double dabble takes two binary bits per step
    localparam int CONV_STEPS = INT_W / 2;
    localparam int MAX_STEPS  = (NUM_DIGITS + 1 > CONV_STEPS) ? NUM_DIGITS + 1 : CONV_STEPS;
    localparam int CNT_W      = $clog2(MAX_STEPS);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_CMP  = 2'd2,
        OP_CONV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic load;
        logic stage_a;
        logic stage_b;
        logic conv_step;
        logic finish;
        op_t  op;
    } ctrl_t;

endpackage

### rtl/core/bcd_decimal_arith_unit.sv
// Top level of the packed BCD add, multiply, compare and convert unit
// One item at a time on NUM_DIGITS packed BCD digits. Add and multiply work
// one decimal column per cycle through a shared digit normalizer, with each
// column sum registered in the cycle before it is normalized. The normalizer's
// carry loop sets this pace. Convert runs a two-bit double dabble over the
// 32-bit integer: 16 steps. Compare finishes at once. A result waits in the
// output register while the next item is taken; the block stalls its input
// from accept until the result is handed to the output register.
`include "bcd_decimal_arith_unit_assert.svh"

module bcd_decimal_arith_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] a_digits,
    input  logic [63:0] b_digits,
    input  logic signed [31:0] int_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] result_digits,
    output logic        overflow,
    output logic        less,
    output logic        equal
);
    import bda_pkg::*;

    ctrl_t ctrl;
    logic  rsp_free;

    logic [RES_W-1:0]                  a_reg, a_next;
    logic [RES_W-1:0]                  b_reg, b_next;
    logic [NUM_DIGITS-1:0][COL_W-1:0]  w_reg, w_next;
    logic [COL_W-1:0]                  u_reg, u_next;
    logic [CARRY_W-1:0]                carry_reg, carry_next;
    logic [RES_W-1:0]                  res_reg, res_next;
    logic [INT_W-1:0]                  int_reg, int_next;
    logic                              lt_reg, lt_next;
    logic                              eq_reg, eq_next;

    logic                              rsp_valid_reg, rsp_valid_next;
    logic [FIELD_W-1:0]                rsp_res_reg, rsp_res_next;
    logic                              rsp_ovf_reg, rsp_ovf_next;
    logic                              rsp_lt_reg, rsp_lt_next;
    logic                              rsp_eq_reg, rsp_eq_next;

    logic [NUM_DIGITS-1:0][PROD_W-1:0] pp;
    logic [SUM_W-1:0]                  col_sum;
    logic [DIG_W-1:0]                  norm_digit;
    logic [CARRY_W-1:0]                norm_carry;
    logic [RES_W-1:0]                  dabble_out;
    logic                              ovf_calc;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    bda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (op_t'(kind)),
        .rsp_free  (rsp_free),
        .ctrl      (ctrl)
    );

    assign col_sum = SUM_W'(u_reg) + SUM_W'(carry_reg);

    bda_digit_norm u_norm (
        .col_sum (col_sum),
        .digit   (norm_digit),
        .carry   (norm_carry)
    );

    bda_dabble_step u_dabble (
        .bcd_in  (res_reg),
        .bits    (int_reg[INT_W-1:INT_W-2]),
        .bcd_out (dabble_out)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            pp[i] = PROD_W'(a_reg[DIG_W*i +: DIG_W]) * PROD_W'(b_reg[DIG_W-1:0]);
        end
    end

    // high part of the product is zero only if the final carry and every
    // leftover column are zero
    always_comb
    begin
        case (ctrl.op)
            OP_ADD:  ovf_calc = (carry_reg != '0);
            OP_MUL:  ovf_calc = (carry_reg != '0) || (|w_reg);
            default: ovf_calc = 1'b0;
        endcase
    end

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        u_next     = u_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        int_next   = int_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;

        if (ctrl.load)
        begin
            a_next     = a_digits[RES_W-1:0];
            b_next     = b_digits[RES_W-1:0];
            w_next     = '0;
            carry_next = '0;
            res_next   = '0;
            // non-positive integers convert to zero
            int_next   = int_value[INT_W-1] ? '0 : $unsigned(int_value);
            lt_next    = (a_digits[RES_W-1:0] < b_digits[RES_W-1:0]);
            eq_next    = (a_digits[RES_W-1:0] == b_digits[RES_W-1:0]);
        end

        if (ctrl.stage_a)
        begin
            if (ctrl.op == OP_ADD)
            begin
                u_next = COL_W'(a_reg[DIG_W-1:0]) + COL_W'(b_reg[DIG_W-1:0]);
                a_next = a_reg >> DIG_W;
            end
            else
            begin
                // add row b_j into the window and slide it down one column
                u_next = w_reg[0] + COL_W'(pp[0]);
                for (int i = 0; i < NUM_DIGITS - 1; i++)
                begin
                    w_next[i] = w_reg[i+1] + COL_W'(pp[i+1]);
                end
                w_next[NUM_DIGITS-1] = '0;
            end
            b_next = b_reg >> DIG_W;
        end

        if (ctrl.stage_b)
        begin
            carry_next = norm_carry;
            res_next   = (res_reg >> DIG_W) | (RES_W'(norm_digit) << (RES_W - DIG_W));
        end

        if (ctrl.conv_step)
        begin
            res_next = dabble_out;
            int_next = int_reg << 2;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_res_next   = rsp_res_reg;
        rsp_ovf_next   = rsp_ovf_reg;
        rsp_lt_next    = rsp_lt_reg;
        rsp_eq_next    = rsp_eq_reg;
        if (ctrl.finish)
        begin
            rsp_valid_next = 1'b1;
            rsp_res_next   = (ctrl.op == OP_CMP) ? '0 : FIELD_W'(res_reg);
            rsp_ovf_next   = ovf_calc;
            rsp_lt_next    = (ctrl.op == OP_CMP) && lt_reg;
            rsp_eq_next    = (ctrl.op == OP_CMP) && eq_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        w_reg       <= w_next;
        u_reg       <= u_next;
        carry_reg   <= carry_next;
        res_reg     <= res_next;
        int_reg     <= int_next;
        lt_reg      <= lt_next;
        eq_reg      <= eq_next;
        rsp_res_reg <= rsp_res_next;
        rsp_ovf_reg <= rsp_ovf_next;
        rsp_lt_reg  <= rsp_lt_next;
        rsp_eq_reg  <= rsp_eq_next;
    end

    assign req_stall     = ctrl.busy;
    assign rsp_valid     = rsp_valid_reg;
    assign result_digits = rsp_res_reg;
    assign overflow      = rsp_ovf_reg;
    assign less          = rsp_lt_reg;
    assign equal         = rsp_eq_reg;

    `BDA_ASSERT_NEXT(a_busy_after_load, ctrl.load, req_stall, "input not stalled after accept")
    `BDA_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid), $past(ctrl.finish), "beat without finish")
    `BDA_ASSERT_NOW(a_cmp_flags, rsp_valid && equal, !less && !overflow, "bad compare flags")
    `BDA_ASSERT_NOW(a_cmp_zero_res, rsp_valid && less, result_digits == '0, "compare result not zero")

endmodule

### rtl/core/bda_digit_norm.sv
// Shared decimal digit normalizer: splits a column sum into digit and carry
module bda_digit_norm (
    input  logic [bda_pkg::SUM_W-1:0]   col_sum,
    output logic [bda_pkg::DIG_W-1:0]   digit,
    output logic [bda_pkg::CARRY_W-1:0] carry
);
    import bda_pkg::*;

    localparam logic [SUM_W-1:0] TEN = SUM_W'(10);

    logic [SUM_W+RECIP_W-1:0] scaled;
    logic [SUM_W-1:0]         quot;
    logic [SUM_W-1:0]         rem;

    always_comb
    begin
        scaled = (SUM_W + RECIP_W)'(col_sum) * (SUM_W + RECIP_W)'(RECIP);
        quot   = SUM_W'(scaled >> RECIP_SH);
        rem    = col_sum - SUM_W'(quot * TEN);
        digit  = rem[DIG_W-1:0];
        carry  = CARRY_W'(quot);
    end

endmodule

### rtl/core/bda_dabble_step.sv
// Two-bit double dabble step for binary to BCD conversion
module bda_dabble_step (
    input  logic [bda_pkg::RES_W-1:0] bcd_in,
    input  logic [1:0]                bits,
    output logic [bda_pkg::RES_W-1:0] bcd_out
);
    import bda_pkg::*;

    logic [RES_W-1:0] acc;

    always_comb
    begin
        acc = bcd_in;
        for (int s = 0; s < 2; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (acc[DIG_W*d +: DIG_W] >= DIG_W'(5))
                begin
                    acc[DIG_W*d +: DIG_W] = acc[DIG_W*d +: DIG_W] + DIG_W'(3);
                end
            end
            // shift in the next binary bit, msb first; digits above the top drop
            acc = {acc[RES_W-2:0], bits[1-s]};
        end
        bcd_out = acc;
    end

endmodule

### rtl/core/bda_ctrl.sv
// Sequencer of the BCD arithmetic unit: step counter and state machine
module bda_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  bda_pkg::op_t    req_op,
    input  logic            rsp_free,
    output bda_pkg::ctrl_t  ctrl
);
    import bda_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op_reg, op_next;
    logic [CNT_W-1:0] last_cnt;

    assign last_cnt = (op_reg == OP_CONV) ? CNT_W'(CONV_STEPS - 1) : CNT_W'(NUM_DIGITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_op;
                    cnt_next   = '0;
                    state_next = (req_op == OP_CMP) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == last_cnt)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.busy      = (state_reg != ST_IDLE);
        ctrl.load      = 1'b0;
        ctrl.stage_a   = 1'b0;
        ctrl.stage_b   = 1'b0;
        ctrl.conv_step = 1'b0;
        ctrl.finish    = 1'b0;
        ctrl.op        = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = req_valid;
            end
            ST_RUN:
            begin
                if (op_reg == OP_CONV)
                begin
                    ctrl.conv_step = 1'b1;
                end
                else
                begin
                    // column products are registered ahead of the normalizer
                    ctrl.stage_a = (cnt_reg < CNT_W'(NUM_DIGITS));
                    ctrl.stage_b = (cnt_reg != '0);
                end
            end
            ST_DONE:
            begin
                ctrl.finish = rsp_free;
            end
            default:
            begin
                ctrl.finish = 1'b0;
            end
        endcase
    end

endmodule
